@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// types and constants for the two stacks sharing one memory
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

    localparam int DSS_DEPTH  = 64;
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [2:0] OP_PUSH_LOW  = 3'd0;
    localparam logic [2:0] OP_POP_LOW   = 3'd1;
    localparam logic [2:0] OP_LIST_LOW  = 3'd2;
    localparam logic [2:0] OP_PUSH_HIGH = 3'd3;
    localparam logic [2:0] OP_POP_HIGH  = 3'd4;
    localparam logic [2:0] OP_LIST_HIGH = 3'd5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_LIST = 2'd2
    } cmd_kind_t;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_LIST = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] word_out;
        status_t            status;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        high;
        logic [31:0] value;
    } cmd_t;

    // result in flight while the memory read completes
    typedef struct packed {
        logic    valid;
        logic    from_ram;
        status_t status;
        logic    last;
    } pend_t;

endpackage

`default_nettype wire

@@ hw/rtl/dss_ram.sv @@
// ----------------------------------------------------------------------------
// dss_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/dss_fifo.sv @@
// ----------------------------------------------------------------------------
// dss_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
`default_nettype none

module dss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = data_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dss_front.sv @@
// ----------------------------------------------------------------------------
// dss_front
// takes input items, decodes the op and queues commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module dss_front import dss_pkg::*; #(
    parameter int CMDQ_D = CMDQ_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_item_t in_item,
    output logic          full,
    output cmd_t          cmd,
    output logic          cmd_valid,
    input  wire logic     cmd_take
);

    cmd_t dec_cmd;
    logic dec_ok;
    logic q_empty;
    logic [$bits(cmd_t)-1:0] q_rd_data;

    always_comb
    begin
        dec_cmd.value = in_item.push_value;
        dec_cmd.kind  = CMD_PUSH;
        dec_cmd.high  = 1'b0;
        dec_ok        = 1'b1;
        case (in_item.op)
            OP_PUSH_LOW:  dec_cmd.kind = CMD_PUSH;
            OP_POP_LOW:   dec_cmd.kind = CMD_POP;
            OP_LIST_LOW:  dec_cmd.kind = CMD_LIST;
            OP_PUSH_HIGH:
            begin
                dec_cmd.kind = CMD_PUSH;
                dec_cmd.high = 1'b1;
            end
            OP_POP_HIGH:
            begin
                dec_cmd.kind = CMD_POP;
                dec_cmd.high = 1'b1;
            end
            OP_LIST_HIGH:
            begin
                dec_cmd.kind = CMD_LIST;
                dec_cmd.high = 1'b1;
            end
            // unused codes are taken and dropped
            default:      dec_ok = 1'b0;
        endcase
    end

    dss_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMDQ_D)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && dec_ok),
        .wr_data (dec_cmd),
        .rd_en   (cmd_take),
        .rd_data (q_rd_data),
        .full    (full),
        .empty   (q_empty),
        .count   ()
    );

    assign cmd       = cmd_t'(q_rd_data);
    assign cmd_valid = !q_empty;

endmodule

`default_nettype wire

@@ hw/rtl/dss_back.sv @@
// ----------------------------------------------------------------------------
// dss_back
// carries out stack commands against the shared ram and streams results
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dss_back import dss_pkg::*; #(
    parameter int DEPTH  = DSS_DEPTH,
    parameter int OUTQ_D = OUTQ_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cmd_t                        cmd,
    input  wire logic                        cmd_valid,
    output logic                             cmd_take,
    input  wire logic [$clog2(OUTQ_D+1)-1:0] out_count,
    output logic                             res_valid,
    output out_item_t                        res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = $clog2(OUTQ_D + 1);

    back_state_t   state_reg, state_next;
    logic [CW-1:0] low_count_reg, low_count_next;
    logic [CW-1:0] high_base_reg, high_base_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          list_high_reg, list_high_next;
    pend_t         pend_reg, pend_next;

    logic          can_issue;
    logic          meet;
    logic          list_last;
    logic [CW-1:0] low_dec, high_dec, idx_dec;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rdata;

    // count plus the result in flight never exceeds the output queue
    assign can_issue = ({1'b0, out_count} + (OW + 1)'(pend_reg.valid)) < (OW + 1)'(OUTQ_D);
    assign meet      = (low_count_reg >= high_base_reg);
    assign low_dec   = low_count_reg - CW'(1);
    assign high_dec  = high_base_reg - CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign list_last = list_high_reg ? (idx_reg == CW'(DEPTH - 1)) : (idx_reg == CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        low_count_next = low_count_reg;
        high_base_next = high_base_reg;
        idx_next       = idx_reg;
        list_high_next = list_high_reg;
        pend_next      = '0;
        pend_next.status = ST_OK;
        cmd_take       = 1'b0;
        we             = 1'b0;
        waddr          = low_count_reg[AW-1:0];
        raddr          = '0;

        case (state_reg)
            BS_IDLE:
            begin
                if (cmd_valid && can_issue)
                begin
                    cmd_take = 1'b1;
                    case (cmd.kind)
                        CMD_PUSH:
                        begin
                            pend_next.valid = 1'b1;
                            pend_next.last  = 1'b1;
                            if (meet)
                            begin
                                pend_next.status = ST_FULL;
                            end
                            else if (!cmd.high)
                            begin
                                we             = 1'b1;
                                waddr          = low_count_reg[AW-1:0];
                                low_count_next = low_count_reg + CW'(1);
                            end
                            else
                            begin
                                we             = 1'b1;
                                waddr          = high_dec[AW-1:0];
                                high_base_next = high_dec;
                            end
                        end
                        CMD_POP:
                        begin
                            pend_next.valid = 1'b1;
                            pend_next.last  = 1'b1;
                            if (!cmd.high)
                            begin
                                if (low_count_reg == '0)
                                begin
                                    pend_next.status = ST_EMPTY;
                                end
                                else
                                begin
                                    pend_next.from_ram = 1'b1;
                                    raddr              = low_dec[AW-1:0];
                                    low_count_next     = low_dec;
                                end
                            end
                            else
                            begin
                                if (high_base_reg >= CW'(DEPTH))
                                begin
                                    pend_next.status = ST_EMPTY;
                                end
                                else
                                begin
                                    pend_next.from_ram = 1'b1;
                                    raddr              = high_base_reg[AW-1:0];
                                    high_base_next     = high_base_reg + CW'(1);
                                end
                            end
                        end
                        CMD_LIST:
                        begin
                            if (!cmd.high && low_count_reg == '0)
                            begin
                                pend_next.valid  = 1'b1;
                                pend_next.last   = 1'b1;
                                pend_next.status = ST_EMPTY;
                            end
                            else if (cmd.high && high_base_reg >= CW'(DEPTH))
                            begin
                                pend_next.valid  = 1'b1;
                                pend_next.last   = 1'b1;
                                pend_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next     = BS_LIST;
                                list_high_next = cmd.high;
                                idx_next       = cmd.high ? high_base_reg : low_count_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BS_LIST:
            begin
                if (can_issue)
                begin
                    pend_next.valid    = 1'b1;
                    pend_next.from_ram = 1'b1;
                    pend_next.last     = list_last;
                    if (list_high_reg)
                    begin
                        raddr    = idx_reg[AW-1:0];
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                    begin
                        raddr    = idx_dec[AW-1:0];
                        idx_next = idx_dec;
                    end
                    if (list_last)
                    begin
                        state_next = BS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            low_count_reg <= '0;
            high_base_reg <= CW'(DEPTH);
            idx_reg       <= '0;
            list_high_reg <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            low_count_reg <= low_count_next;
            high_base_reg <= high_base_next;
            idx_reg       <= idx_next;
            list_high_reg <= list_high_next;
            pend_reg      <= pend_next;
        end
    end

    dss_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign res_valid       = pend_reg.valid;
    assign res.word_out    = pend_reg.from_ram ? $signed(rdata) : '0;
    assign res.status      = pend_reg.status;
    assign res.last_of_run = pend_reg.last;

    `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, low_count_reg <= high_base_reg,
        "low stack ran into high stack")
    `ASSERT_ALWAYS(a_high_bound, clk, rst_n, high_base_reg <= CW'(DEPTH),
        "high base beyond memory")
    `ASSERT_IMPLIES(a_room_for_result, clk, rst_n, pend_reg.valid, out_count < OW'(OUTQ_D),
        "result transfer into a full output queue")
    `ASSERT_IMPLIES(a_list_low_idx, clk, rst_n, state_reg == BS_LIST && !list_high_reg,
        idx_reg != '0, "low list walked past slot zero")
    `ASSERT_NEXT(a_list_no_take, clk, rst_n, state_reg == BS_IDLE && state_next == BS_LIST,
        !cmd_take, "command taken while a list is running")

endmodule

`default_nettype wire

@@ hw/rtl/dual_stack_shared_memory.sv @@
// a push or pop result passes the command queue, the back end register and the output queue
// throughput: one push or pop per cycle via the single ram access, if the out queue has room
// a list of n words reads the ram once per word and takes no new command until its last read
// reset: asynchronous, active low; both stacks empty, queues empty, no clearing pass
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// two stacks in one ram: low stack grows up from slot 0, high stack down from the top
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stack_shared_memory import dss_pkg::*; #(
    parameter int DEPTH  = DSS_DEPTH,
    parameter int CMDQ_D = CMDQ_DEPTH,
    parameter int OUTQ_D = OUTQ_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     out_item
);

    cmd_t      cmd;
    logic      cmd_valid;
    logic      cmd_take;
    logic      res_valid;
    out_item_t res;
    logic [$clog2(OUTQ_D+1)-1:0]  out_count;
    logic [$bits(out_item_t)-1:0] out_rd_data;

    dss_front #(
        .CMDQ_D (CMDQ_D)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    dss_back #(
        .DEPTH  (DEPTH),
        .OUTQ_D (OUTQ_D)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .out_count (out_count),
        .res_valid (res_valid),
        .res       (res)
    );

    // result queue, the back end keeps room for every result in flight
    dss_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUTQ_D)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .full    (),
        .empty   (empty),
        .count   (out_count)
    );

    assign out_item = out_item_t'(out_rd_data);

endmodule

`default_nettype wire
